// File: rtl/vna_pkg.sv
// Shared constants, codes and types of the vertex normal accumulator.
`default_nettype none

package vna_pkg;

    // Default store depth.
    localparam int unsigned VERTEX_SLOTS_DEF = 1024;

    // Field widths.
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned POS_W  = 24;
    localparam int unsigned NRM_W  = 18;
    localparam int unsigned POS_BITS = 3 * POS_W;
    localparam int unsigned NRM_BITS = 3 * NRM_W;

    // Arithmetic widths.
    localparam int unsigned DIFF_W = 25;
    localparam int unsigned SUM_W  = 52;
    localparam int unsigned MAG_W  = 30;
    localparam int unsigned SQ_W   = 60;
    localparam int unsigned SSUM_W = 62;
    localparam int unsigned QUO_W  = 35;
    localparam int unsigned ROOT_W = 18;
    localparam int unsigned Q_W    = 17;
    localparam int unsigned MUL_W  = 32;
    localparam int unsigned FRAC_STEPS = 34;

    // Reciprocal used to fold an index into the store depth.
    localparam int unsigned RECIP_SH = 20;
    localparam int unsigned RECIP_W  = 19;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Write strobes toward the vertex store.
    typedef struct packed {
        logic pos_we;
        logic nrm_we;
    } t_store_wr;

endpackage

`default_nettype wire

// File: rtl/vna_in_if.sv
// Request channel carrying vertex commands into the accumulator.
`default_nettype none

interface vna_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      command;
    logic [vna_pkg::IDX_W-1:0]       index_a;
    logic [vna_pkg::IDX_W-1:0]       index_b;
    logic [vna_pkg::IDX_W-1:0]       index_c;
    logic signed [vna_pkg::POS_W-1:0] pos_x;
    logic signed [vna_pkg::POS_W-1:0] pos_y;
    logic signed [vna_pkg::POS_W-1:0] pos_z;
    logic signed [vna_pkg::NRM_W-1:0] init_nx;
    logic signed [vna_pkg::NRM_W-1:0] init_ny;
    logic signed [vna_pkg::NRM_W-1:0] init_nz;

    modport source (
        output valid, command, index_a, index_b, index_c,
        output pos_x, pos_y, pos_z, init_nx, init_ny, init_nz,
        input  ready
    );
    modport sink (
        input  valid, command, index_a, index_b, index_c,
        input  pos_x, pos_y, pos_z, init_nx, init_ny, init_nz,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/vna_out_if.sv
// Result channel carrying normals out of the accumulator.
`default_nettype none

interface vna_out_if;
    logic                             valid;
    logic                             ready;
    logic [vna_pkg::IDX_W-1:0]        vertex_slot;
    logic signed [vna_pkg::NRM_W-1:0] out_nx;
    logic signed [vna_pkg::NRM_W-1:0] out_ny;
    logic signed [vna_pkg::NRM_W-1:0] out_nz;
    logic                             last;

    modport source (
        output valid, vertex_slot, out_nx, out_ny, out_nz, last,
        input  ready
    );
    modport sink (
        input  valid, vertex_slot, out_nx, out_ny, out_nz, last,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/vna_store.sv
// Vertex store: position and normal memories with one shared address port.
`default_nettype none

module vna_store #(
    parameter int unsigned SLOTS = vna_pkg::VERTEX_SLOTS_DEF,
    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic [AW-1:0]                   i_addr,
    input  wire vna_pkg::t_store_wr              i_wr,
    input  wire logic [vna_pkg::POS_BITS-1:0]    i_pos,
    input  wire logic [vna_pkg::NRM_BITS-1:0]    i_nrm,
    output logic [vna_pkg::POS_BITS-1:0]         o_pos,
    output logic [vna_pkg::NRM_BITS-1:0]         o_nrm
);

    logic [vna_pkg::POS_BITS-1:0] r_pos_mem [SLOTS];
    logic [vna_pkg::NRM_BITS-1:0] r_nrm_mem [SLOTS];
    logic [vna_pkg::POS_BITS-1:0] r_pos;
    logic [vna_pkg::NRM_BITS-1:0] r_nrm;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.pos_we) begin
            r_pos_mem[i_addr] <= i_pos;
        end
        if (i_wr.nrm_we) begin
            r_nrm_mem[i_addr] <= i_nrm;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_pos <= r_pos_mem[i_addr];
        r_nrm <= r_nrm_mem[i_addr];
    end

    assign o_pos = r_pos;
    assign o_nrm = r_nrm;

endmodule

`default_nettype wire

// File: rtl/vna_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module vna_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [vna_pkg::MUL_W-1:0]    i_a,
    input  wire logic signed [vna_pkg::MUL_W-1:0]    i_b,
    output logic signed [2*vna_pkg::MUL_W-1:0]       o_prod
);

    logic signed [2*vna_pkg::MUL_W-1:0] r_prod;

    // One product per cycle, available on the next cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/vna_divsqrt.sv
// Iterative unit: q = round(sqrt(sq * 2^34 / sum) / 2) by long division then root.
`default_nettype none

module vna_divsqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [vna_pkg::SQ_W-1:0]      i_sq,
    input  wire logic [vna_pkg::SSUM_W-1:0]    i_sum,
    output logic                               o_done,
    output logic [vna_pkg::Q_W-1:0]            o_q
);

    typedef enum logic [3:0] {
        DS_IDLE = 4'b0001,
        DS_DIV  = 4'b0010,
        DS_SQRT = 4'b0100,
        DS_DONE = 4'b1000
    } t_ds_state;

    localparam int unsigned RAD_W  = 2 * vna_pkg::ROOT_W;
    localparam int unsigned SREM_W = vna_pkg::ROOT_W + 2;
    localparam int unsigned CUR_W  = SREM_W + 2;

    t_ds_state                     r_state, n_state;
    logic [5:0]                    r_cnt, n_cnt;
    logic [vna_pkg::SSUM_W-1:0]    r_den;
    logic [vna_pkg::SSUM_W-1:0]    r_rem;
    logic [vna_pkg::QUO_W-1:0]     r_quo;
    logic [RAD_W-1:0]              r_rad;
    logic [SREM_W-1:0]             r_srem;
    logic [vna_pkg::ROOT_W-1:0]    r_root;

    logic [vna_pkg::SSUM_W-1:0]    sq_ext;
    logic                          init_ge;
    logic [vna_pkg::SSUM_W:0]      rem_sh;
    logic                          div_ge;
    logic [vna_pkg::QUO_W-1:0]     quo_nx;
    logic [CUR_W-1:0]              cur;
    logic [CUR_W-1:0]              trial;
    logic                          sq_ge;
    logic [vna_pkg::ROOT_W:0]      rnd;

    // Division and root step logic.
    always_comb begin
        sq_ext  = {2'b00, i_sq};
        init_ge = (sq_ext >= i_sum);
        rem_sh  = {r_rem, 1'b0};
        div_ge  = (rem_sh >= {1'b0, r_den});
        quo_nx  = {r_quo[vna_pkg::QUO_W-2:0], div_ge};
        cur     = {r_srem, r_rad[RAD_W-1 -: 2]};
        trial   = CUR_W'({r_root, 2'b01});
        sq_ge   = (cur >= trial);
        rnd     = {1'b0, r_root} + (vna_pkg::ROOT_W + 1)'(1);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            DS_IDLE: begin
                if (i_start) begin
                    n_state = DS_DIV;
                    n_cnt   = 6'(vna_pkg::FRAC_STEPS - 1);
                end
            end
            DS_DIV: begin
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = DS_SQRT;
                    n_cnt   = 6'(vna_pkg::ROOT_W - 1);
                end
            end
            DS_SQRT: begin
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_state = DS_DONE;
                end
            end
            DS_DONE: begin
                n_state = DS_IDLE;
            end
            default: begin
                n_state = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath: restoring division, then restoring square root two bits a step.
    always_ff @(posedge i_clk) begin
        case (r_state)
            DS_IDLE: begin
                r_den <= i_sum;
                if (init_ge) begin
                    r_rem <= sq_ext - i_sum;
                    r_quo <= vna_pkg::QUO_W'(1);
                end else begin
                    r_rem <= sq_ext;
                    r_quo <= '0;
                end
            end
            DS_DIV: begin
                if (div_ge) begin
                    r_rem <= vna_pkg::SSUM_W'(rem_sh - {1'b0, r_den});
                end else begin
                    r_rem <= rem_sh[vna_pkg::SSUM_W-1:0];
                end
                r_quo  <= quo_nx;
                r_rad  <= RAD_W'(quo_nx);
                r_srem <= '0;
                r_root <= '0;
            end
            DS_SQRT: begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                if (sq_ge) begin
                    r_srem <= SREM_W'(cur - trial);
                    r_root <= {r_root[vna_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_srem <= cur[SREM_W-1:0];
                    r_root <= {r_root[vna_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            default: begin
                r_den <= r_den;
            end
        endcase
    end

    assign o_done = (r_state == DS_DONE);
    assign o_q    = rnd[vna_pkg::Q_W:1];

endmodule

`default_nettype wire

// File: rtl/vertex_normal_accumulate.sv
// Top level of the vertex normal accumulator: command sequencer and datapath.
// Requests are taken one at a time: the input stays closed until the previous one is done.
// A triangle keeps the input closed until its results are emitted; when no corner sum is zero, each
// of its nine normal components goes through the shared divide and root unit, and
// each corner first scales its sum below 2^30. Results leave a, b, c in turn.
// Reset (synchronous, active low) clears the sequencer and the output valid; memories keep data.
`default_nettype none

module vertex_normal_accumulate #(
    parameter int unsigned VERTEX_SLOTS = vna_pkg::VERTEX_SLOTS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vna_in_if.sink      i_in,
    vna_out_if.source   o_out
);

    localparam int unsigned AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int unsigned IW = vna_pkg::IDX_W;
    localparam int unsigned PW = vna_pkg::POS_W;
    localparam int unsigned NW = vna_pkg::NRM_W;
    localparam int unsigned DW = vna_pkg::DIFF_W;
    localparam int unsigned SW = vna_pkg::SUM_W;
    localparam int unsigned MW = vna_pkg::MUL_W;
    localparam int unsigned RW = vna_pkg::RECIP_W;
    localparam int unsigned RECIP_I = (VERTEX_SLOTS >= 1024) ? 0 :
        ((1 << vna_pkg::RECIP_SH) + VERTEX_SLOTS - 1) / VERTEX_SLOTS;
    localparam logic [RW-1:0] RECIP = RW'(RECIP_I);
    localparam logic [IW-1:0] MODV  = (VERTEX_SLOTS >= 1024) ? IW'(0) : IW'(VERTEX_SLOTS);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RED0   = 14'b00000000000010,
        S_RED1   = 14'b00000000000100,
        S_LOAD   = 14'b00000000001000,
        S_RDREQ  = 14'b00000000010000,
        S_RDEMIT = 14'b00000000100000,
        S_FETCH  = 14'b00000001000000,
        S_CROSS  = 14'b00000010000000,
        S_SUMV   = 14'b00000100000000,
        S_SHIFT  = 14'b00001000000000,
        S_SQ     = 14'b00010000000000,
        S_NSTART = 14'b00100000000000,
        S_NWAIT  = 14'b01000000000000,
        S_EMIT   = 14'b10000000000000
    } t_state;

    // Control registers.
    t_state       r_state, n_state;
    logic [2:0]   r_cnt, n_cnt;
    logic [1:0]   r_vi, n_vi;
    logic [1:0]   r_j, n_j;
    logic         r_out_valid, n_out_valid;

    // Datapath registers.
    vna_pkg::t_cmd                      r_cmd;
    logic [IW-1:0]                      r_idx  [3];
    logic [IW-1:0]                      r_qt   [3];
    logic [IW-1:0]                      r_slot [3];
    logic [vna_pkg::POS_BITS-1:0]       r_ld_pos;
    logic [vna_pkg::NRM_BITS-1:0]       r_ld_nrm;
    logic signed [PW-1:0]               r_p0 [3];
    logic signed [DW-1:0]               r_v1 [3];
    logic signed [DW-1:0]               r_v2 [3];
    logic signed [NW-1:0]               r_n  [3][3];
    logic signed [SW-1:0]               r_f  [3];
    logic [SW-1:0]                      r_mag [3];
    logic                               r_neg [3];
    logic [vna_pkg::SQ_W-1:0]           r_sq  [3];
    logic [vna_pkg::SSUM_W-1:0]         r_ssum;
    logic signed [NW-1:0]               r_res [3][3];
    logic [IW-1:0]                      r_out_slot;
    logic signed [NW-1:0]               r_out_n [3];
    logic                               r_out_last;

    // Internal nets.
    logic                               in_acc;
    logic                               out_free;
    logic                               out_load;
    logic [1:0]                         sel;
    logic [2:0]                         pc;
    logic [AW-1:0]                      st_addr;
    vna_pkg::t_store_wr                 st_wr;
    logic [vna_pkg::POS_BITS-1:0]       st_pos_w;
    logic [vna_pkg::NRM_BITS-1:0]       st_nrm_w;
    logic [vna_pkg::POS_BITS-1:0]       st_pos_r;
    logic [vna_pkg::NRM_BITS-1:0]       st_nrm_r;
    logic signed [PW-1:0]               rd_p [3];
    logic signed [NW-1:0]               rd_n [3];
    logic signed [MW-1:0]               mul_a, mul_b;
    logic signed [2*MW-1:0]             mul_p;
    logic signed [SW-1:0]               prod_s;
    logic                               ds_start;
    logic                               ds_done;
    logic [vna_pkg::Q_W-1:0]            ds_q;
    logic signed [NW-1:0]               q_signed;
    logic signed [SW-1:0]               s_sum [3];
    logic                               big;
    logic                               all_zero;
    logic [RW+IW-1:0]                   qt_full [3];
    logic [2*IW-1:0]                    qm_full [3];

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ((r_state == S_EMIT) || (r_state == S_RDEMIT)) && out_free;
    assign sel      = (r_cnt == 3'd3) ? 2'd2 : r_cnt[1:0];
    assign pc       = r_cnt - 3'd1;
    assign ds_start = (r_state == S_NSTART);

    // Store read fields.
    assign rd_p[0] = st_pos_r[3*PW-1 -: PW];
    assign rd_p[1] = st_pos_r[2*PW-1 -: PW];
    assign rd_p[2] = st_pos_r[PW-1 -: PW];
    assign rd_n[0] = st_nrm_r[3*NW-1 -: NW];
    assign rd_n[1] = st_nrm_r[2*NW-1 -: NW];
    assign rd_n[2] = st_nrm_r[NW-1 -: NW];

    // Store port control.
    always_comb begin
        st_addr  = AW'(r_slot[0]);
        st_wr    = '0;
        st_pos_w = r_ld_pos;
        st_nrm_w = r_ld_nrm;
        case (r_state)
            S_LOAD: begin
                st_wr.pos_we = 1'b1;
                st_wr.nrm_we = 1'b1;
            end
            S_FETCH: begin
                st_addr = AW'(r_slot[sel]);
            end
            S_EMIT: begin
                st_addr      = AW'(r_slot[sel]);
                st_wr.nrm_we = out_free;
                st_nrm_w     = {r_res[sel][0], r_res[sel][1], r_res[sel][2]};
            end
            default: begin
                st_addr = AW'(r_slot[0]);
            end
        endcase
    end

    // Multiplier operand selection: cross product terms, then squared magnitudes.
    always_comb begin
        mul_a = MW'(r_mag[sel][vna_pkg::MAG_W-1:0]);
        mul_b = MW'(r_mag[sel][vna_pkg::MAG_W-1:0]);
        if (r_state == S_CROSS) begin
            case (r_cnt)
                3'd0: begin mul_a = MW'(r_v1[1]); mul_b = MW'(r_v2[2]); end
                3'd1: begin mul_a = MW'(r_v1[2]); mul_b = MW'(r_v2[1]); end
                3'd2: begin mul_a = MW'(r_v1[2]); mul_b = MW'(r_v2[0]); end
                3'd3: begin mul_a = MW'(r_v1[0]); mul_b = MW'(r_v2[2]); end
                3'd4: begin mul_a = MW'(r_v1[0]); mul_b = MW'(r_v2[1]); end
                3'd5: begin mul_a = MW'(r_v1[1]); mul_b = MW'(r_v2[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod_s = SW'(mul_p);

    // Sum of the scaled stored normal and the face normal, the range tests and the index fold products.
    always_comb begin
        big      = 1'b0;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            s_sum[i] = {{(SW-NW-8){r_n[r_vi][i][NW-1]}}, r_n[r_vi][i], 8'b0} + r_f[i];
            big      = big | (|r_mag[i][SW-1:vna_pkg::MAG_W]);
            all_zero = all_zero & (r_mag[i] == '0);
            qt_full[i] = r_idx[i] * RECIP;
            qm_full[i] = r_qt[i] * MODV;
        end
    end

    assign q_signed = r_neg[r_j] ? -NW'(ds_q) : NW'(ds_q);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_vi        = r_vi;
        n_j         = r_j;
        n_out_valid = (r_out_valid && !o_out.ready) || out_load;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RED0;
                end
            end
            S_RED0: begin
                n_state = S_RED1;
            end
            S_RED1: begin
                n_cnt = '0;
                case (r_cmd)
                    vna_pkg::CMD_LOAD: n_state = S_LOAD;
                    vna_pkg::CMD_READ: n_state = S_RDREQ;
                    vna_pkg::CMD_TRI:  n_state = S_FETCH;
                    default:           n_state = S_IDLE;
                endcase
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            S_RDREQ: begin
                n_state = S_RDEMIT;
            end
            S_RDEMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_state = S_CROSS;
                    n_cnt   = '0;
                end
            end
            S_CROSS: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    n_state = S_SUMV;
                    n_vi    = '0;
                end
            end
            S_SUMV: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (!big) begin
                    n_cnt = '0;
                    if (!all_zero) begin
                        n_state = S_SQ;
                    end else if (r_vi == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SUMV;
                        n_vi    = r_vi + 2'd1;
                    end
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_state = S_NSTART;
                    n_j     = '0;
                end
            end
            S_NSTART: begin
                n_state = S_NWAIT;
            end
            S_NWAIT: begin
                if (ds_done) begin
                    n_cnt = '0;
                    if (r_j != 2'd2) begin
                        n_state = S_NSTART;
                        n_j     = r_j + 2'd1;
                    end else if (r_vi == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SUMV;
                        n_vi    = r_vi + 2'd1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd2) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_vi        <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_vi        <= n_vi;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers, loaded by state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_cmd    <= vna_pkg::t_cmd'(i_in.command);
                    r_idx[0] <= i_in.index_a;
                    r_idx[1] <= i_in.index_b;
                    r_idx[2] <= i_in.index_c;
                    r_ld_pos <= {i_in.pos_x, i_in.pos_y, i_in.pos_z};
                    r_ld_nrm <= {i_in.init_nx, i_in.init_ny, i_in.init_nz};
                end
            end
            S_RED0: begin
                for (int i = 0; i < 3; i++) begin
                    r_qt[i] <= IW'(qt_full[i] >> vna_pkg::RECIP_SH);
                end
            end
            S_RED1: begin
                for (int i = 0; i < 3; i++) begin
                    r_slot[i] <= r_idx[i] - qm_full[i][IW-1:0];
                end
            end
            S_FETCH: begin
                // Read data arrives in the cycle after its address is set.
                if (r_cnt != 3'd0) begin
                    r_n[pc[1:0]] <= rd_n;
                end
                for (int i = 0; i < 3; i++) begin
                    if (r_cnt == 3'd1) begin
                        r_p0[i] <= rd_p[i];
                    end
                    if (r_cnt == 3'd2) begin
                        r_v1[i] <= DW'(r_p0[i]) - DW'(rd_p[i]);
                    end
                    if (r_cnt == 3'd3) begin
                        r_v2[i] <= DW'(rd_p[i]) - DW'(r_p0[i]);
                        r_f[i]  <= '0;
                    end
                end
            end
            S_CROSS: begin
                // Even terms add, odd terms subtract.
                if (r_cnt != 3'd0) begin
                    if (pc[0]) begin
                        r_f[pc[2:1]] <= r_f[pc[2:1]] - prod_s;
                    end else begin
                        r_f[pc[2:1]] <= r_f[pc[2:1]] + prod_s;
                    end
                end
            end
            S_SUMV: begin
                r_ssum <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= s_sum[i][SW-1];
                    r_mag[i] <= s_sum[i][SW-1] ? SW'(-s_sum[i]) : SW'(s_sum[i]);
                end
            end
            S_SHIFT: begin
                if (big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end else if (all_zero) begin
                    for (int i = 0; i < 3; i++) begin
                        r_res[r_vi][i] <= '0;
                    end
                end
            end
            S_SQ: begin
                if (r_cnt != 3'd0) begin
                    r_sq[pc[1:0]] <= mul_p[vna_pkg::SQ_W-1:0];
                    r_ssum        <= r_ssum + vna_pkg::SSUM_W'(mul_p[vna_pkg::SQ_W-1:0]);
                end
            end
            S_NWAIT: begin
                if (ds_done) begin
                    r_res[r_vi][r_j] <= q_signed;
                end
            end
            default: begin
                r_cmd <= r_cmd;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_RDEMIT) begin
                r_out_slot <= r_slot[0];
                r_out_n    <= rd_n;
                r_out_last <= 1'b1;
            end else begin
                r_out_slot <= r_slot[sel];
                r_out_n    <= r_res[sel];
                r_out_last <= (r_cnt == 3'd2);
            end
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.vertex_slot = r_out_slot;
    assign o_out.out_nx      = r_out_n[0];
    assign o_out.out_ny      = r_out_n[1];
    assign o_out.out_nz      = r_out_n[2];
    assign o_out.last        = r_out_last;

    vna_store #(
        .SLOTS (VERTEX_SLOTS)
    ) u_store (
        .i_clk  (i_clk),
        .i_addr (st_addr),
        .i_wr   (st_wr),
        .i_pos  (st_pos_w),
        .i_nrm  (st_nrm_w),
        .o_pos  (st_pos_r),
        .o_nrm  (st_nrm_r)
    );

    vna_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    vna_divsqrt u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ds_start),
        .i_sq    (r_sq[r_j]),
        .i_sum   (r_ssum),
        .o_done  (ds_done),
        .o_q     (ds_q)
    );

endmodule

`default_nettype wire

// File: rtl/vna_check.sv
// Port-level checks of the vertex normal accumulator, bound to the top level.
`default_nettype none

module vna_check (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [vna_pkg::IDX_W-1:0]        i_out_slot,
    input wire logic signed [vna_pkg::NRM_W-1:0] i_out_nx,
    input wire logic                             i_out_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_slot) && $stable(i_out_nx) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // An accepted request keeps the block busy on the next cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while the previous one is in work");

    // No new request before the last result of a triangle is under way.
    a_no_req_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |-> !i_in_ready)
        else $error("request window opened inside a result burst");

endmodule

bind vertex_normal_accumulate vna_check u_vna_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_slot  (o_out.vertex_slot),
    .i_out_nx    (o_out.out_nx),
    .i_out_last  (o_out.last)
);

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the vertex normal accumulator: directed and random requests with a scoreboard.
`timescale 1ns / 100ps

// Scoreboard: keeps its own copy of the vertex store and predicts normals.
class normal_scoreboard;
    typedef struct {
        logic [vna_pkg::IDX_W-1:0]        slot;
        logic signed [vna_pkg::NRM_W-1:0] nx;
        logic signed [vna_pkg::NRM_W-1:0] ny;
        logic signed [vna_pkg::NRM_W-1:0] nz;
        logic                             last;
    } t_normal;

    longint  pos_x[1024], pos_y[1024], pos_z[1024];
    longint  nrm_x[1024], nrm_y[1024], nrm_z[1024];
    t_normal expected_normals[$];
    int      errors = 0;

    function int pending();
        return expected_normals.size();
    endfunction

    // Append one expectation at the tail of the queue.
    function void add_expected(t_normal e);
        expected_normals.insert(expected_normals.size(), e);
    endfunction

    // True when (2q-1)^2 * S <= m^2 * 2^34, that is q - 1/2 is at most the exact value sqrt(m^2 * 2^34 / S) / 2.
    function bit below_root(longint unsigned q, longint unsigned sum_sq, longint unsigned m);
        bit [127:0] lhs, rhs, t;
        t   = 128'(2 * q - 1);
        lhs = t * t * 128'(sum_sq);
        rhs = (128'(m) * 128'(m)) << 34;
        return lhs <= rhs;
    endfunction

    // Renormalize a product-scale sum to a unit Q1.16 vector.
    function void unit_vector(input longint s[3], output longint r[3]);
        longint unsigned mag[3], mx, sum_sq, lo, hi, mid;
        int k;
        mx = 0;
        sum_sq = 0;
        k = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (s[i] < 0) ? -s[i] : s[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            r[0] = 0; r[1] = 0; r[2] = 0;
            return;
        end
        while ((mx >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++) begin
            mag[i] = mag[i] >> k;
            sum_sq += mag[i] * mag[i];
        end
        for (int i = 0; i < 3; i++) begin
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (below_root(mid, sum_sq, mag[i])) lo = mid;
                else hi = mid - 1;
            end
            r[i] = (s[i] < 0) ? -longint'(lo) : longint'(lo);
        end
    endfunction

    // Note an accepted request and queue the normals it should produce.
    function void note_request(vna_pkg::t_cmd cmd, logic [vna_pkg::IDX_W-1:0] ia,
                               logic [vna_pkg::IDX_W-1:0] ib, logic [vna_pkg::IDX_W-1:0] ic,
                               logic signed [vna_pkg::POS_W-1:0] px,
                               logic signed [vna_pkg::POS_W-1:0] py,
                               logic signed [vna_pkg::POS_W-1:0] pz,
                               logic signed [vna_pkg::NRM_W-1:0] nx,
                               logic signed [vna_pkg::NRM_W-1:0] ny,
                               logic signed [vna_pkg::NRM_W-1:0] nz);
        int      slot[3];
        longint  d1[3], d2[3], face[3], s[3], res[3][3];
        t_normal e;
        slot[0] = ia; slot[1] = ib; slot[2] = ic;
        case (cmd)
            vna_pkg::CMD_LOAD: begin
                pos_x[ia] = px; pos_y[ia] = py; pos_z[ia] = pz;
                nrm_x[ia] = nx; nrm_y[ia] = ny; nrm_z[ia] = nz;
            end
            vna_pkg::CMD_READ: begin
                e.slot = ia;
                e.nx = vna_pkg::NRM_W'(nrm_x[ia]);
                e.ny = vna_pkg::NRM_W'(nrm_y[ia]);
                e.nz = vna_pkg::NRM_W'(nrm_z[ia]);
                e.last = 1'b1;
                add_expected(e);
            end
            vna_pkg::CMD_TRI: begin
                d1[0] = pos_x[ia] - pos_x[ib]; d2[0] = pos_x[ic] - pos_x[ia];
                d1[1] = pos_y[ia] - pos_y[ib]; d2[1] = pos_y[ic] - pos_y[ia];
                d1[2] = pos_z[ia] - pos_z[ib]; d2[2] = pos_z[ic] - pos_z[ia];
                face[0] = d1[1] * d2[2] - d1[2] * d2[1];
                face[1] = d1[2] * d2[0] - d1[0] * d2[2];
                face[2] = d1[0] * d2[1] - d1[1] * d2[0];
                // All corner sums use the normals from before this triangle.
                for (int i = 0; i < 3; i++) begin
                    s[0] = nrm_x[slot[i]] * 256 + face[0];
                    s[1] = nrm_y[slot[i]] * 256 + face[1];
                    s[2] = nrm_z[slot[i]] * 256 + face[2];
                    unit_vector(s, res[i]);
                end
                // Write-back goes a, b, c, so a repeated corner keeps the last one.
                for (int i = 0; i < 3; i++) begin
                    nrm_x[slot[i]] = res[i][0];
                    nrm_y[slot[i]] = res[i][1];
                    nrm_z[slot[i]] = res[i][2];
                    e.slot = vna_pkg::IDX_W'(slot[i]);
                    e.nx = vna_pkg::NRM_W'(res[i][0]);
                    e.ny = vna_pkg::NRM_W'(res[i][1]);
                    e.nz = vna_pkg::NRM_W'(res[i][2]);
                    e.last = (i == 2);
                    add_expected(e);
                end
            end
            default: ;
        endcase
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(logic [vna_pkg::IDX_W-1:0] slot,
                               logic signed [vna_pkg::NRM_W-1:0] nx,
                               logic signed [vna_pkg::NRM_W-1:0] ny,
                               logic signed [vna_pkg::NRM_W-1:0] nz,
                               logic last);
        t_normal e;
        if (expected_normals.size() == 0) begin
            $error("unexpected result: slot %0d", slot);
            errors++;
            return;
        end
        e = expected_normals.pop_front();
        if (slot !== e.slot) begin
            $error("vertex_slot: expected %0d, got %0d", e.slot, slot); errors++;
        end
        if (nx !== e.nx) begin
            $error("out_nx: expected %0d, got %0d", e.nx, nx); errors++;
        end
        if (ny !== e.ny) begin
            $error("out_ny: expected %0d, got %0d", e.ny, ny); errors++;
        end
        if (nz !== e.nz) begin
            $error("out_nz: expected %0d, got %0d", e.nz, nz); errors++;
        end
        if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last); errors++;
        end
    endfunction
endclass

module tb_top;
    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    bit   loaded[1024];
    int   pool[$];
    int   stall_left;

    vna_in_if  in_ch();
    vna_out_if out_ch();

    normal_scoreboard board;

    vertex_normal_accumulate DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock.
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Result side: check each accepted result and stall in random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.vertex_slot, out_ch.out_nx, out_ch.out_ny,
                               out_ch.out_nz, out_ch.last);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Send one request, with an occasional idle burst before it.
    task automatic send_request(vna_pkg::t_cmd cmd, int ia, int ib, int ic,
                                logic signed [vna_pkg::POS_W-1:0] px,
                                logic signed [vna_pkg::POS_W-1:0] py,
                                logic signed [vna_pkg::POS_W-1:0] pz,
                                logic signed [vna_pkg::NRM_W-1:0] nx,
                                logic signed [vna_pkg::NRM_W-1:0] ny,
                                logic signed [vna_pkg::NRM_W-1:0] nz);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.index_a <= vna_pkg::IDX_W'(ia);
        in_ch.index_b <= vna_pkg::IDX_W'(ib);
        in_ch.index_c <= vna_pkg::IDX_W'(ic);
        in_ch.pos_x   <= px; in_ch.pos_y   <= py; in_ch.pos_z   <= pz;
        in_ch.init_nx <= nx; in_ch.init_ny <= ny; in_ch.init_nz <= nz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_request(cmd, vna_pkg::IDX_W'(ia), vna_pkg::IDX_W'(ib), vna_pkg::IDX_W'(ic),
                           px, py, pz, nx, ny, nz);
        if (cmd == vna_pkg::CMD_LOAD) begin
            if (!loaded[ia]) pool.insert(pool.size(), ia);
            loaded[ia] = 1'b1;
        end
    endtask

    task automatic load_vertex(int slot, logic signed [vna_pkg::POS_W-1:0] px,
                               logic signed [vna_pkg::POS_W-1:0] py,
                               logic signed [vna_pkg::POS_W-1:0] pz,
                               logic signed [vna_pkg::NRM_W-1:0] nx,
                               logic signed [vna_pkg::NRM_W-1:0] ny,
                               logic signed [vna_pkg::NRM_W-1:0] nz);
        send_request(vna_pkg::CMD_LOAD, slot, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     px, py, pz, nx, ny, nz);
    endtask

    task automatic triangle(int ia, int ib, int ic);
        send_request(vna_pkg::CMD_TRI, ia, ib, ic,
                     vna_pkg::POS_W'($urandom), vna_pkg::POS_W'($urandom),
                     vna_pkg::POS_W'($urandom), vna_pkg::NRM_W'($urandom),
                     vna_pkg::NRM_W'($urandom), vna_pkg::NRM_W'($urandom));
    endtask

    task automatic read_normal(int slot);
        send_request(vna_pkg::CMD_READ, slot, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     vna_pkg::POS_W'($urandom), vna_pkg::POS_W'($urandom),
                     vna_pkg::POS_W'($urandom), vna_pkg::NRM_W'($urandom),
                     vna_pkg::NRM_W'($urandom), vna_pkg::NRM_W'($urandom));
    endtask

    function automatic logic signed [vna_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return vna_pkg::POS_W'($urandom);
            1:       return vna_pkg::POS_W'($signed($urandom_range(0, 8191)) - 4096);
            default: return vna_pkg::POS_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic signed [vna_pkg::NRM_W-1:0] rand_nrm();
        if ($urandom_range(0, 3) == 0) return vna_pkg::NRM_W'($urandom);
        return vna_pkg::NRM_W'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic int pick_loaded();
        return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Stimulus.
    initial begin
        int r;
        board = new();
        quiet = 1'b0;
        stall_left = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = vna_pkg::CMD_NONE;
        in_ch.index_a = '0; in_ch.index_b = '0; in_ch.index_c = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
        in_ch.init_nx = '0; in_ch.init_ny = '0; in_ch.init_nz = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every command, repeated corners and a zero sum.
        load_vertex(0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                    18'sh1FFFF, 18'sh20000, 18'sh00000);
        load_vertex(1023, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
                    18'sh20000, 18'sh1FFFF, 18'sh1FFFF);
        load_vertex(512, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, '0, '0, 18'sh20000);
        load_vertex(1, '0, '0, '0, '0, '0, '0);
        load_vertex(2, '0, '0, '0, '0, '0, '0);
        load_vertex(3, 24'sd4096, '0, '0, '0, '0, 18'sd65536);
        load_vertex(4, '0, 24'sd4096, '0, '0, '0, '0);
        read_normal(0);
        read_normal(1023);
        triangle(0, 1023, 512);
        triangle(1, 2, 1);
        triangle(3, 3, 3);
        triangle(1, 3, 4);
        triangle(4, 1023, 4);
        send_request(vna_pkg::CMD_NONE, 1023, 1023, 1023,
                     24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                     18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF);
        read_normal(1);
        read_normal(3);
        read_normal(4);

        // Hold off until every expected result has come.
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);

        // Random: mostly loads into a small set and triangles over loaded slots.
        for (int n = 0; n < 460; n++) begin
            if (n == 400) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 30 || pool.size() < 3) begin
                load_vertex((r < 10) ? $urandom_range(0, 1023) : $urandom_range(0, 15),
                            rand_pos(), rand_pos(), rand_pos(),
                            rand_nrm(), rand_nrm(), rand_nrm());
            end else if (r < 70) begin
                triangle(pick_loaded(), pick_loaded(), pick_loaded());
            end else if (r < 95) begin
                read_normal(pick_loaded());
            end else begin
                send_request(vna_pkg::CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023),
                             vna_pkg::POS_W'($urandom), vna_pkg::POS_W'($urandom),
                             vna_pkg::POS_W'($urandom), vna_pkg::NRM_W'($urandom),
                             vna_pkg::NRM_W'($urandom), vna_pkg::NRM_W'($urandom));
            end
        end
        in_ch.valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
